### design/lsm_pkg.sv
// ----------------------------------------------------------------------------
// Latency statistics monitor package
// Shared transaction types, command codes and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package lsm_pkg;

	localparam int CMD_W   = 2;
	localparam int CHAN_W  = 2;
	localparam int TS_W    = 64;
	localparam int COUNT_W = 32;
	localparam int DIV_CNT_W = $clog2(TS_W);

	localparam logic [CMD_W-1:0] CMD_ENTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EXIT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [CHAN_W-1:0] channel;
		logic [TS_W-1:0]   timestamp;
	} item_t;

	typedef struct packed {
		logic [CHAN_W-1:0]  report_channel;
		logic               updated;
		logic [COUNT_W-1:0] event_count;
		logic [TS_W-1:0]    last_latency;
		logic [TS_W-1:0]    lowest_lat;
		logic [TS_W-1:0]    highest_lat;
		logic [TS_W-1:0]    mean_lat;
	} result_t;

	typedef struct packed {
		logic load_item;
		logic start_exit;
		logic mul_lo;
		logic mul_hi;
		logic sum_lo;
		logic sum_hi;
		logic div_step;
		logic apply;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic measure;
		logic div_last;
	} dp_status_t;

endpackage

### design/lsm_ctrl.sv
// ----------------------------------------------------------------------------
// Latency statistics monitor controller
// Sequences one transaction at a time through decode, the average update
// (two partial products, a wide sum, a bit-serial division) and the result.
// ----------------------------------------------------------------------------
module lsm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	output logic              result_valid,
	input  logic              result_ready,
	input  lsm_pkg::dp_status_t status,
	output lsm_pkg::ctrl_cmd_t  cmd
);
	import lsm_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECIDE = 4'd1;
	localparam logic [3:0] S_MUL_LO = 4'd2;
	localparam logic [3:0] S_MUL_HI = 4'd3;
	localparam logic [3:0] S_SUM_LO = 4'd4;
	localparam logic [3:0] S_SUM_HI = 4'd5;
	localparam logic [3:0] S_DIV    = 4'd6;
	localparam logic [3:0] S_APPLY  = 4'd7;
	localparam logic [3:0] S_RESULT = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_next;
	logic       out_valid_q;
	logic       slot_free;

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;
	assign slot_free    = !out_valid_q || result_ready;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_next    = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (status.measure) begin
					cmd.start_exit = 1'b1;
					state_next     = S_MUL_LO;
				end else begin
					state_next = S_APPLY;
				end
			end
			S_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_next = S_MUL_HI;
			end
			S_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_next = S_SUM_LO;
			end
			S_SUM_LO: begin
				cmd.sum_lo = 1'b1;
				state_next = S_SUM_HI;
			end
			S_SUM_HI: begin
				cmd.sum_hi = 1'b1;
				state_next = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_next = S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.apply  = 1'b1;
				state_next = S_RESULT;
			end
			S_RESULT: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_next   = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### design/lsm_datapath.sv
// ----------------------------------------------------------------------------
// Latency statistics monitor datapath
// Per-channel statistics registers, latency and average arithmetic with a
// shared 32-by-32 multiplier step and a restoring divider, and the result
// register.
// ----------------------------------------------------------------------------
module lsm_datapath #(
	parameter int NUM_CHANNELS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_wr_data,
	input  lsm_pkg::item_t       item,
	input  lsm_pkg::ctrl_cmd_t   cmd,
	output lsm_pkg::dp_status_t  status,
	output lsm_pkg::result_t     result
);
	import lsm_pkg::*;

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int HALF_W = TS_W / 2;

	logic [COUNT_W-1:0] count_q [NUM_CHANNELS];
	logic [TS_W-1:0]    start_q [NUM_CHANNELS];
	logic [TS_W-1:0]    min_q   [NUM_CHANNELS];
	logic [TS_W-1:0]    max_q   [NUM_CHANNELS];
	logic [TS_W-1:0]    avg_q   [NUM_CHANNELS];
	logic               enable_q;

	item_t              item_q;
	logic               updated_q;
	logic [TS_W-1:0]    last_q;
	logic [TS_W-1:0]    lat_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [COUNT_W-1:0] m_q;
	logic [TS_W-1:0]    avg_in_q;
	logic [TS_W-1:0]    prod_lo_q;
	logic [TS_W-1:0]    prod_hi_q;
	logic [TS_W:0]      acc_q;
	logic [COUNT_W-1:0] rem_q;
	logic [TS_W-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	result_t            result_q;

	logic [IDX_W-1:0]   ch_idx;
	logic               ch_valid;
	logic [COUNT_W-1:0] cur_count;
	logic [TS_W-1:0]    cur_start;
	logic [TS_W-1:0]    cur_min;
	logic [TS_W-1:0]    cur_max;
	logic [TS_W-1:0]    cur_avg;
	logic               is_clear;
	logic               do_enter;
	logic               measure;
	logic [COUNT_W-1:0] mul_a;
	logic [TS_W-1:0]    mul_p;
	logic [TS_W+HALF_W-1:0] num;
	logic [COUNT_W:0]   trial;
	logic [COUNT_W:0]   diff;
	logic               take;

	assign ch_idx   = IDX_W'(item_q.channel);
	assign ch_valid = (int'(item_q.channel) < NUM_CHANNELS);

	assign cur_count = ch_valid ? count_q[ch_idx] : '0;
	assign cur_start = ch_valid ? start_q[ch_idx] : '0;
	assign cur_min   = ch_valid ? min_q[ch_idx]   : '1;
	assign cur_max   = ch_valid ? max_q[ch_idx]   : '0;
	assign cur_avg   = ch_valid ? avg_q[ch_idx]   : '0;

	assign is_clear = (item_q.command == CMD_CLEAR);
	assign do_enter = enable_q && ch_valid && (item_q.command == CMD_ENTER);
	assign measure  = enable_q && ch_valid && (item_q.command == CMD_EXIT)
		&& (cur_count != '0) && (item_q.timestamp >= cur_start);

	assign status.measure  = measure;
	assign status.div_last = (div_cnt_q == '0);

	assign mul_a = cmd.mul_hi ? avg_in_q[TS_W-1:HALF_W] : avg_in_q[HALF_W-1:0];
	assign mul_p = TS_W'(mul_a) * TS_W'(m_q);

	assign num = {prod_hi_q, {HALF_W{1'b0}}} + (TS_W+HALF_W)'(acc_q);

	assign trial = {rem_q, quo_q[TS_W-1]};
	assign diff  = trial - {1'b0, cnt_q};
	assign take  = (trial >= {1'b0, cnt_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			enable_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				count_q[i] <= '0;
				start_q[i] <= '0;
				min_q[i]   <= '1;
				max_q[i]   <= '0;
				avg_q[i]   <= '0;
			end
		end else if (cmd.apply) begin
			if (is_clear) begin
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					count_q[i] <= '0;
					start_q[i] <= '0;
					min_q[i]   <= '1;
					max_q[i]   <= '0;
					avg_q[i]   <= '0;
				end
			end else if (do_enter) begin
				if (cur_count != '1) begin
					count_q[ch_idx] <= cur_count + COUNT_W'(1);
				end
				start_q[ch_idx] <= item_q.timestamp;
			end else if (measure) begin
				if (lat_q < cur_min) begin
					min_q[ch_idx] <= lat_q;
				end
				if (lat_q > cur_max) begin
					max_q[ch_idx] <= lat_q;
				end
				avg_q[ch_idx] <= quo_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
		end
		if (cmd.start_exit) begin
			lat_q    <= item_q.timestamp - cur_start;
			cnt_q    <= cur_count;
			m_q      <= cur_count - COUNT_W'(1);
			avg_in_q <= cur_avg;
		end
		if (cmd.mul_lo) begin
			prod_lo_q <= mul_p;
		end
		if (cmd.mul_hi) begin
			prod_hi_q <= mul_p;
		end
		if (cmd.sum_lo) begin
			acc_q <= {1'b0, prod_lo_q} + {1'b0, lat_q};
		end
		if (cmd.sum_hi) begin
			rem_q     <= num[TS_W+HALF_W-1:TS_W];
			quo_q     <= num[TS_W-1:0];
			div_cnt_q <= DIV_CNT_W'(TS_W - 1);
		end else if (cmd.div_step) begin
			rem_q     <= take ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
			quo_q     <= {quo_q[TS_W-2:0], take};
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end
		if (cmd.apply) begin
			updated_q <= is_clear || do_enter || measure;
			last_q    <= (!is_clear && !do_enter && measure) ? lat_q : '0;
		end
		if (cmd.load_out) begin
			result_q.report_channel <= item_q.channel;
			result_q.updated        <= updated_q;
			result_q.event_count    <= cur_count;
			result_q.last_latency   <= last_q;
			result_q.lowest_lat     <= cur_min;
			result_q.highest_lat    <= cur_max;
			result_q.mean_lat       <= cur_avg;
		end
	end

	assign result = result_q;

endmodule

### design/latency_statistics_monitor.sv
// ----------------------------------------------------------------------------
// Latency statistics monitor
// Per-channel event counts and min, max and running average latency.
// ----------------------------------------------------------------------------
// Enter, clear, ignored and disabled transactions go from accept through decode, an update and a result load.
// A measuring exit goes through a decode state, two multiplier
// passes, a two-step 96-bit sum, a bit-serial divide, an update and a result load.
// The next transaction is accepted the cycle after the result loads;
// a stalled result holds the following transaction in its last state until the output frees.
// Reset clears enable and sets every channel to count 0, min all ones, max 0, avg 0.
module latency_statistics_monitor #(
	parameter int NUM_CHANNELS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic             cfg_wr_data,
	input  logic             item_valid,
	output logic             item_ready,
	input  lsm_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output lsm_pkg::result_t result
);
	import lsm_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	lsm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	lsm_datapath #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item        (item),
		.cmd         (cmd),
		.status      (status),
		.result      (result)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("Monitor accepted a transaction while one was in flight.");

	a_latency_only_when_updated: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.updated |-> result.last_latency == '0)
		else $error("Nonzero latency reported without an update.");

	a_latency_within_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.updated && (result.last_latency != '0)
		|-> (result.lowest_lat <= result.last_latency)
		&& (result.highest_lat >= result.last_latency))
		else $error("Reported latency lies outside the min and max bounds.");
`endif

endmodule

### sim/tb_latency_statistics_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Latency statistics monitor testbench
// Directed and random enter, exit, clear and no-op transactions run against a
// self-checking model of the per-channel count, min, max and average latency.
// The enable register is toggled between phases, and both handshakes see
// random idle and stall cycles.
// ----------------------------------------------------------------------------
module tb_latency_statistics_monitor;
	import lsm_pkg::*;

	localparam int                NUM_CHANNELS = 4;
	localparam logic [CMD_W-1:0]  CMD_NOP      = 2'd3;
	localparam logic [TS_W-1:0]   TS_ALL_ONES  = '1;
	localparam logic [TS_W-1:0]   NS_PER_SEC   = 64'd1_000_000_000;
	localparam int                HANG_LIMIT   = 3000;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    cfg_wr_en    = 1'b0;
	logic    cfg_wr_data  = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_ready;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	item_t   pending_items[$];
	result_t expected_stats[$];

	logic               monitor_enable;
	logic [COUNT_W-1:0] chan_count [NUM_CHANNELS];
	logic [TS_W-1:0]    chan_start [NUM_CHANNELS];
	logic [TS_W-1:0]    chan_min   [NUM_CHANNELS];
	logic [TS_W-1:0]    chan_max   [NUM_CHANNELS];
	logic [TS_W-1:0]    chan_avg   [NUM_CHANNELS];

	logic [TS_W-1:0]    gen_start  [NUM_CHANNELS];

	int      error_count  = 0;
	int      burst_left   = 0;
	int      gap_left     = 0;
	int      idle_cycles  = 0;
	logic [31:0] ready_pattern = '1;
	logic [4:0]  pattern_pos   = '0;

	latency_statistics_monitor #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always #5 clk = ~clk;

	function automatic void clear_statistics();
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			chan_count[i] = '0;
			chan_start[i] = '0;
			chan_min[i]   = TS_ALL_ONES;
			chan_max[i]   = '0;
			chan_avg[i]   = '0;
		end
	endfunction

	function automatic result_t predict_statistics(input item_t it);
		result_t           r;
		logic [CHAN_W-1:0] ch;
		logic [95:0]       weighted;
		logic [95:0]       quotient;
		ch = it.channel;
		r  = '0;
		r.report_channel = ch;
		case (it.command)
		CMD_CLEAR: begin
			clear_statistics();
			r.updated = 1'b1;
		end
		CMD_ENTER: begin
			if (monitor_enable) begin
				if (chan_count[ch] != '1)
					chan_count[ch] = chan_count[ch] + COUNT_W'(1);
				chan_start[ch] = it.timestamp;
				r.updated = 1'b1;
			end
		end
		CMD_EXIT: begin
			if (monitor_enable && chan_count[ch] != '0 && it.timestamp >= chan_start[ch]) begin
				r.last_latency = it.timestamp - chan_start[ch];
				if (r.last_latency < chan_min[ch])
					chan_min[ch] = r.last_latency;
				if (r.last_latency > chan_max[ch])
					chan_max[ch] = r.last_latency;
				weighted = {32'd0, chan_avg[ch]} * ({64'd0, chan_count[ch]} - 96'd1)
					+ {32'd0, r.last_latency};
				quotient = weighted / {64'd0, chan_count[ch]};
				chan_avg[ch] = quotient[TS_W-1:0];
				r.updated = 1'b1;
			end
		end
		default: ;
		endcase
		r.event_count = chan_count[ch];
		r.lowest_lat  = chan_min[ch];
		r.highest_lat = chan_max[ch];
		r.mean_lat    = chan_avg[ch];
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t ns: %s", $time, what);
		error_count++;
	endtask

	task automatic compare_field(input string name, input logic [TS_W-1:0] got,
		input logic [TS_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	// Driver: the prediction is made when the transaction is accepted.
	always @(posedge clk) begin
		logic  next_valid;
		item_t next_item;
		next_valid = item_valid;
		next_item  = item;
		if (item_valid && item_ready) begin
			expected_stats.push_back(predict_statistics(item));
			next_valid = 1'b0;
		end
		if (!next_valid && arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_items.size() > 0) begin
				next_item  = pending_items.pop_front();
				next_valid = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 16);
					gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
				end
			end
		end
		item_valid <= next_valid;
		item       <= next_item;
	end

	// Monitor and receiver stall pattern.
	always @(posedge clk) begin
		result_t want;
		logic [31:0] next_pattern;
		if (result_valid && result_ready) begin
			if (expected_stats.size() == 0) begin
				report_mismatch("result transaction with no expected result");
			end else begin
				want = expected_stats.pop_front();
				compare_field("report_channel", TS_W'(result.report_channel),
					TS_W'(want.report_channel));
				compare_field("updated", TS_W'(result.updated), TS_W'(want.updated));
				compare_field("event_count", TS_W'(result.event_count),
					TS_W'(want.event_count));
				compare_field("last_latency", result.last_latency, want.last_latency);
				compare_field("lowest_lat", result.lowest_lat, want.lowest_lat);
				compare_field("highest_lat", result.highest_lat, want.highest_lat);
				compare_field("mean_lat", result.mean_lat, want.mean_lat);
			end
		end
		next_pattern = {ready_pattern[0], ready_pattern[31:1]};
		if (pattern_pos == 5'd31) begin
			case ($urandom_range(0, 3))
			0: next_pattern = '1;
			1: next_pattern = $urandom;
			2: next_pattern = $urandom & $urandom;
			default: next_pattern = $urandom | $urandom;
			endcase
		end
		ready_pattern <= next_pattern;
		pattern_pos   <= pattern_pos + 5'd1;
		result_ready  <= arst_n ? ready_pattern[0] : 1'b0;
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == HANG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] ch,
		input logic [TS_W-1:0] ts);
		item_t it;
		it.command   = cmd;
		it.channel   = ch;
		it.timestamp = ts;
		pending_items.push_back(it);
	endtask

	task automatic write_enable(input logic value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		monitor_enable = value;
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || item_valid || expected_stats.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [TS_W-1:0] random_time();
		logic [TS_W-1:0] t;
		t = {$urandom, $urandom};
		if ($urandom_range(0, 1))
			t = t >> $urandom_range(0, 63);
		return t;
	endfunction

	function automatic logic [TS_W-1:0] random_latency();
		case ($urandom_range(0, 4))
		0: return 64'd0;
		1: return 64'($urandom_range(0, 100));
		2: return 64'($urandom);
		3: return NS_PER_SEC * 64'($urandom_range(1, 5));
		default: return {$urandom, $urandom} >> $urandom_range(0, 63);
		endcase
	endfunction

	task automatic run_random(input int useful_target);
		int                useful;
		int                pick;
		logic [CHAN_W-1:0] ch;
		logic [TS_W-1:0]   ts;
		logic [TS_W-1:0]   lat;
		useful = 0;
		while (useful < useful_target) begin
			pick = $urandom_range(0, 99);
			ch   = CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
			if (pick < 38 || (pick < 84 && pick >= 79 && gen_start[ch] <= 64'd1000)) begin
				ts = random_time();
				gen_start[ch] = ts;
				push_item(CMD_ENTER, ch, ts);
				useful++;
			end else if (pick < 79) begin
				lat = random_latency();
				ts  = gen_start[ch] + lat;
				if (ts < gen_start[ch])
					ts = TS_ALL_ONES;
				push_item(CMD_EXIT, ch, ts);
				useful++;
			end else if (pick < 84) begin
				push_item(CMD_EXIT, ch, gen_start[ch] - 64'($urandom_range(1, 1000)));
			end else if (pick < 86) begin
				push_item(CMD_CLEAR, ch, random_time());
				useful++;
			end else if (pick < 90) begin
				push_item(CMD_NOP, ch, random_time());
			end else begin
				push_item(CMD_W'($urandom_range(0, 3)), ch, {$urandom, $urandom});
			end
		end
	endtask

	initial begin
		monitor_enable = 1'b0;
		clear_statistics();
		for (int i = 0; i < NUM_CHANNELS; i++)
			gen_start[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		write_enable(1'b0);
		push_item(CMD_ENTER, 2'd0, 64'd100);
		push_item(CMD_EXIT, 2'd0, 64'd200);
		push_item(CMD_NOP, 2'd2, TS_ALL_ONES);
		push_item(CMD_CLEAR, 2'd1, 64'd0);
		wait_idle();

		write_enable(1'b1);
		push_item(CMD_EXIT, 2'd0, 64'd50);
		push_item(CMD_ENTER, 2'd0, 64'd0);
		push_item(CMD_EXIT, 2'd0, 64'd0);
		push_item(CMD_EXIT, 2'd0, TS_ALL_ONES);
		push_item(CMD_ENTER, 2'd1, TS_ALL_ONES);
		push_item(CMD_EXIT, 2'd1, 64'd5);
		push_item(CMD_EXIT, 2'd1, TS_ALL_ONES);
		push_item(CMD_ENTER, 2'd2, 64'd1000);
		push_item(CMD_EXIT, 2'd2, 64'd1000 + NS_PER_SEC);
		push_item(CMD_ENTER, 2'd2, 64'd2 * NS_PER_SEC);
		push_item(CMD_EXIT, 2'd2, 64'd2 * NS_PER_SEC + 64'd7);
		push_item(CMD_ENTER, 2'd3, 64'h5555_5555_5555_5555);
		push_item(CMD_EXIT, 2'd3, 64'hAAAA_AAAA_AAAA_AAAA);
		push_item(CMD_NOP, 2'd3, TS_ALL_ONES);
		for (int i = 0; i < 5; i++)
			push_item(CMD_ENTER, 2'd1, 64'd0);
		push_item(CMD_EXIT, 2'd1, TS_ALL_ONES);
		push_item(CMD_EXIT, 2'd1, TS_ALL_ONES);
		push_item(CMD_EXIT, 2'd1, 64'h8000_0000_0000_0001);
		push_item(CMD_CLEAR, 2'd0, 64'h1234_5678_9ABC_DEF0);
		push_item(CMD_EXIT, 2'd0, TS_ALL_ONES);
		wait_idle();

		run_random(720);
		wait_idle();

		write_enable(1'b0);
		run_random(120);
		wait_idle();

		write_enable(1'b1);
		run_random(600);
		wait_idle();

		repeat (80) @(posedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
